[hw/rtl/ctf_pkg.sv]
// ctf_pkg: shared types, constants and small functions of the circle fan block
// used by ctf_front, ctf_queue, ctf_back and circle_triangle_fan_top
`timescale 1ns / 1ps

package ctf_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_W        = 7;
    localparam int N_ENTRIES    = 12;

    // trig series runs in unsigned q30
    localparam int TRIG_SH = 30 - FRAC_BITS;
    localparam int MAG_W   = FRAC_BITS + 1;
    localparam int ACC_W   = 66 - FRAC_BITS;

    localparam logic [31:0] ONE_Q    = 32'(64'd1 << FRAC_BITS);
    localparam logic [63:0] HALF_Q   = 64'd1 << (FRAC_BITS - 1);
    localparam logic [30:0] HALF_T   = 31'd1 << (TRIG_SH - 1);
    localparam logic [30:0] TRIG_ONE = 31'h4000_0000;
    localparam logic [31:0] PI4_Q30  = 32'd843314857;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef struct packed {
        logic              is_draw;
        logic [3:0]        idx;
        logic [31:0]       value;
        logic [31:0]       cx;
        logic [31:0]       cy;
        logic [30:0]       rad;
        logic [31:0]       z;
        logic [SEG_W-1:0]  seg;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_XMUL, S_X2, S_XSQ, S_X2R, S_TMUL, S_TDIV, S_RMUL,
        S_CORR, S_SMUL, S_SREG, S_ROT, S_RXMUL, S_RXADD, S_RYMUL, S_RYADD,
        S_MMUL, S_MACC, S_VDONE, S_EMIT
    } t_state;

    // series divisors: five sine terms then six cosine terms
    function automatic logic [7:0] ser_div(input logic [3:0] i);
        case (i)
            4'd0:    return 8'd110;
            4'd1:    return 8'd72;
            4'd2:    return 8'd42;
            4'd3:    return 8'd20;
            4'd4:    return 8'd6;
            4'd5:    return 8'd132;
            4'd6:    return 8'd90;
            4'd7:    return 8'd56;
            4'd8:    return 8'd30;
            4'd9:    return 8'd12;
            4'd10:   return 8'd2;
            default: return 8'd1;
        endcase
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] ser_recip(input logic [3:0] i);
        case (i)
            4'd0:    return 32'd39045157;
            4'd1:    return 32'd59652323;
            4'd2:    return 32'd102261126;
            4'd3:    return 32'd214748364;
            4'd4:    return 32'd715827882;
            4'd5:    return 32'd32537631;
            4'd6:    return 32'd47721858;
            4'd7:    return 32'd76695844;
            4'd8:    return 32'd143165576;
            4'd9:    return 32'd357913941;
            4'd10:   return 32'd2147483648;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > SAT_HI) begin
            return 32'h7FFF_FFFF;
        end else if (v < SAT_LO) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

[hw/rtl/circle_triangle_fan_top.sv]
// circle_triangle_fan_top: top level of the circle fan tessellator
// depends on ctf_pkg, ctf_front, ctf_queue, ctf_back
`timescale 1ns / 1ps

// Tessellates a circle into a fan of triangles and transforms each vertex by
// a stored 3x4 affine matrix, all in signed q16.16. A load item (action 0)
// writes one matrix entry, row*4+column; entries 12..15 are ignored. A draw
// item (action 1) with n segments gives n result items, the last one flagged;
// n of zero gives none and n above 64 counts as 64. Items pass a two-entry
// queue, so input is taken while a draw is still running. A draw runs the phase
// division, then the centre vertex, then each rim point in turn: the single
// shared 32x32 multiplier runs the eleven sine/cosine series steps and the
// nine matrix products one after another. Any output stall holds the draw,
// since the next rim point starts only once the triangle is taken.

module circle_triangle_fan_top import ctf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [3:0]        i_entry_index,
    input  logic [31:0]       i_entry_value,
    input  logic [31:0]       i_center_x,
    input  logic [31:0]       i_center_y,
    input  logic [30:0]       i_radius,
    input  logic [31:0]       i_depth_z,
    input  logic [SEG_W-1:0]  i_segments,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_a_x,
    output logic [31:0]       o_a_y,
    output logic [31:0]       o_a_z,
    output logic [31:0]       o_b_x,
    output logic [31:0]       o_b_y,
    output logic [31:0]       o_b_z,
    output logic [31:0]       o_c_x,
    output logic [31:0]       o_c_y,
    output logic [31:0]       o_c_z,
    output logic              o_last
);

    // front to queue
    logic push_valid;
    t_cmd push_cmd;
    logic push_stall;

    // queue to back
    logic pop_valid;
    t_cmd pop_cmd;
    logic pop_stall;

    // classify and clamp each item
    ctf_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_depth_z     (i_depth_z),
        .i_segments    (i_segments),
        .o_push_valid  (push_valid),
        .o_push_cmd    (push_cmd),
        .i_push_stall  (push_stall)
    );

    // short queue keeps loads in order behind running draws
    ctf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_stall (push_stall),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_stall  (pop_stall)
    );

    // matrix store, trig and transform, result register
    ctf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_stall (pop_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_a_x       (o_a_x),
        .o_a_y       (o_a_y),
        .o_a_z       (o_a_z),
        .o_b_x       (o_b_x),
        .o_b_y       (o_b_y),
        .o_b_z       (o_b_z),
        .o_c_x       (o_c_x),
        .o_c_y       (o_c_y),
        .o_c_z       (o_c_z),
        .o_last      (o_last)
    );

endmodule

[hw/rtl/ctf_front.sv]
// ctf_front: accepts input items, drops the ones with no effect, clamps segment count
// depends on ctf_pkg; feeds ctf_queue
`timescale 1ns / 1ps

module ctf_front import ctf_pkg::*; (
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [3:0]        i_entry_index,
    input  logic [31:0]       i_entry_value,
    input  logic [31:0]       i_center_x,
    input  logic [31:0]       i_center_y,
    input  logic [30:0]       i_radius,
    input  logic [31:0]       i_depth_z,
    input  logic [SEG_W-1:0]  i_segments,
    output logic              o_push_valid,
    output t_cmd              o_push_cmd,
    input  logic              i_push_stall
);

    logic [SEG_W-1:0] seg_clamp;
    logic             keep;

    assign seg_clamp = (i_segments > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : i_segments;

    // loads past the last entry and empty draws leave no trace
    always_comb begin
        case (i_action)
            ACT_LOAD: keep = (i_entry_index < 4'(N_ENTRIES));
            ACT_DRAW: keep = (i_segments != '0);
            default:  keep = 1'b0;
        endcase
    end

    assign o_push_valid       = i_valid && keep;
    assign o_stall            = i_push_stall;
    assign o_push_cmd.is_draw = (i_action == ACT_DRAW);
    assign o_push_cmd.idx     = i_entry_index;
    assign o_push_cmd.value   = i_entry_value;
    assign o_push_cmd.cx      = i_center_x;
    assign o_push_cmd.cy      = i_center_y;
    assign o_push_cmd.rad     = i_radius;
    assign o_push_cmd.z       = i_depth_z;
    assign o_push_cmd.seg     = seg_clamp;

endmodule

[hw/rtl/ctf_queue.sv]
// ctf_queue: two-entry command queue between front and back
// depends on ctf_pkg (t_cmd)
`timescale 1ns / 1ps

module ctf_queue import ctf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_stall,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop_stall
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_stall = (r_cnt == 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign push         = i_push_valid && !o_push_stall;
    assign pop          = o_pop_valid && !i_pop_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

[hw/rtl/ctf_back.sv]
// ctf_back: matrix store, phase divider, sine/cosine series, transform and result register
// depends on ctf_pkg; one shared 32x32 multiplier serves all but the quotient correction
`timescale 1ns / 1ps

module ctf_back import ctf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_a_x,
    output logic [31:0] o_a_y,
    output logic [31:0] o_a_z,
    output logic [31:0] o_b_x,
    output logic [31:0] o_b_y,
    output logic [31:0] o_b_z,
    output logic [31:0] o_c_x,
    output logic [31:0] o_c_y,
    output logic [31:0] o_c_z,
    output logic        o_last
);

    t_state r_state, n_state;

    logic [31:0]             r_mat [N_ENTRIES];
    logic [31:0]             r_cx, r_cy, r_z;
    logic [30:0]             r_rad;
    logic [SEG_W-1:0]        r_n, r_pt;
    logic [5:0]              r_dcnt;
    logic [5:0]              r_rem, r_rem0;
    logic [31:0]             r_step, r_phase;
    logic [1:0]              r_quad;
    logic                    r_mirror;
    logic [29:0]             r_x, r_x2;
    logic [30:0]             r_t, r_v, r_s;
    logic [3:0]              r_i;
    logic [MAG_W-1:0]        r_cmag, r_smag;
    logic                    r_cneg, r_sneg;
    logic [31:0]             r_px, r_py;
    logic [1:0]              r_row, r_j;
    logic signed [ACC_W-1:0] r_acc;
    logic [31:0]             r_res [3];
    logic [31:0]             r_cen [3];
    logic [31:0]             r_prev [3];
    logic                    r_cent;
    logic [63:0]             r_prod;
    logic                    r_psign;
    logic                    r_ovalid;
    logic [31:0]             r_oa [3];
    logic [31:0]             r_ob [3];
    logic [31:0]             r_oc [3];
    logic                    r_olast;

    logic [31:0] mul_a, mul_b;
    logic        mul_neg;
    logic        emit_fire;

    // divider step for 2^32 / n
    logic [6:0] div_sh;
    logic       div_ge;
    logic [5:0] div_rem;
    assign div_sh  = {r_rem0, (r_dcnt == 6'd0)};
    assign div_ge  = (div_sh >= r_n);
    assign div_rem = div_ge ? 6'(div_sh - r_n) : div_sh[5:0];

    // phase advance to the next rim point
    logic [6:0] adv_sum;
    logic       adv_wrap;
    assign adv_sum  = {1'b0, r_rem} + {1'b0, r_rem0};
    assign adv_wrap = (adv_sum >= r_n);

    // octant fold
    logic [29:0] rfrac, xr;
    logic        mirror;
    assign rfrac  = r_phase[29:0];
    assign mirror = (rfrac > 30'h2000_0000);
    assign xr     = mirror ? 30'(31'h4000_0000 - {1'b0, rfrac}) : rfrac;

    // rounding of the shared product
    logic [63:0] x_sum, q30_sum, prnd;
    logic [30:0] q30r;
    logic [ACC_W-2:0] pmag;
    logic signed [ACC_W-1:0] psig;
    assign x_sum   = r_prod + 64'h1000_0000;
    assign q30_sum = r_prod + 64'h2000_0000;
    assign q30r    = q30_sum[60:30];
    assign prnd    = (r_prod + HALF_Q) >> FRAC_BITS;
    assign pmag    = prnd[ACC_W-2:0];
    assign psig    = r_psign ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});

    // reciprocal quotient correction
    logic [7:0]  sdiv;
    logic [30:0] q0, qn;
    logic [38:0] qd;
    logic [39:0] qrem;
    assign sdiv = ser_div(r_i);
    assign q0   = r_prod[62:32];
    assign qd   = 39'(q0) * 39'(sdiv);
    assign qrem = 40'(r_v) - {1'b0, qd};
    assign qn   = (qrem >= 40'(sdiv)) ? q0 + 31'd1 : q0;

    // quadrant rotation
    logic [30:0]      cbig, sbig, csum, ssum;
    logic [MAG_W-1:0] cm, sm;
    assign cbig = r_mirror ? r_s : r_t;
    assign sbig = r_mirror ? r_t : r_s;
    assign csum = cbig + HALF_T;
    assign ssum = sbig + HALF_T;
    assign cm   = csum[30:TRIG_SH];
    assign sm   = ssum[30:TRIG_SH];

    logic signed [ACC_W-1:0] rim_x, rim_y;
    assign rim_x = ACC_W'($signed(r_cx)) + psig;
    assign rim_y = ACC_W'($signed(r_cy)) + psig;

    logic [31:0] m_sel, v_sel;
    assign m_sel = r_mat[{r_row, r_j}];
    assign v_sel = (r_j == 2'd0) ? r_px : ((r_j == 2'd1) ? r_py : r_z);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_cmd_valid && i_cmd.is_draw) n_state = S_DIV;
            S_DIV:   if (r_dcnt == 6'd32) n_state = S_MMUL;
            S_XMUL:  n_state = S_X2;
            S_X2:    n_state = S_XSQ;
            S_XSQ:   n_state = S_X2R;
            S_X2R:   n_state = S_TMUL;
            S_TMUL:  n_state = S_TDIV;
            S_TDIV:  n_state = S_RMUL;
            S_RMUL:  n_state = S_CORR;
            S_CORR: begin
                if (r_i == 4'd4) begin
                    n_state = S_SMUL;
                end else if (r_i == 4'd10) begin
                    n_state = S_ROT;
                end else begin
                    n_state = S_TMUL;
                end
            end
            S_SMUL:  n_state = S_SREG;
            S_SREG:  n_state = S_TMUL;
            S_ROT:   n_state = S_RXMUL;
            S_RXMUL: n_state = S_RXADD;
            S_RXADD: n_state = S_RYMUL;
            S_RYMUL: n_state = S_RYADD;
            S_RYADD: n_state = S_MMUL;
            S_MMUL: begin
                if (r_j != 2'd3) begin
                    n_state = S_MACC;
                end else if (r_row == 2'd2) begin
                    n_state = S_VDONE;
                end
            end
            S_MACC:  n_state = S_MMUL;
            S_VDONE: n_state = (r_cent || r_pt == '0) ? S_XMUL : S_EMIT;
            S_EMIT: begin
                if (emit_fire) begin
                    n_state = (r_pt == r_n) ? S_IDLE : S_XMUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operands and handshake outputs
    always_comb begin
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        mul_neg = 1'b0;
        case (r_state)
            S_XMUL: begin
                mul_a = 32'(xr);
                mul_b = PI4_Q30;
            end
            S_XSQ: begin
                mul_a = 32'(r_x);
                mul_b = 32'(r_x);
            end
            S_TMUL: begin
                mul_a = 32'(r_x2);
                mul_b = 32'(r_t);
            end
            S_RMUL: begin
                mul_a = 32'(r_v);
                mul_b = ser_recip(r_i);
            end
            S_SMUL: begin
                mul_a = 32'(r_x);
                mul_b = 32'(r_t);
            end
            S_RXMUL: begin
                mul_a   = {1'b0, r_rad};
                mul_b   = 32'(r_cmag);
                mul_neg = r_cneg;
            end
            S_RYMUL: begin
                mul_a   = {1'b0, r_rad};
                mul_b   = 32'(r_smag);
                mul_neg = r_sneg;
            end
            S_MMUL: begin
                mul_a   = mag32(m_sel);
                mul_b   = mag32(v_sel);
                mul_neg = m_sel[31] ^ v_sel[31];
            end
            default: begin
                mul_a = 32'd0;
            end
        endcase
    end

    assign o_cmd_stall = (r_state != S_IDLE);
    assign emit_fire   = (r_state == S_EMIT) && (!r_ovalid || !i_stall);

    // control state and matrix store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            // identity rows
            for (int e = 0; e < N_ENTRIES; e++) begin
                r_mat[e] <= (e == 0 || e == 5 || e == 10) ? ONE_Q : 32'd0;
            end
        end else begin
            r_state <= n_state;
            if (emit_fire) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_IDLE && i_cmd_valid && !i_cmd.is_draw) begin
                r_mat[i_cmd.idx] <= i_cmd.value;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod  <= 64'(mul_a) * 64'(mul_b);
        r_psign <= mul_neg;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.is_draw) begin
                    r_cx   <= i_cmd.cx;
                    r_cy   <= i_cmd.cy;
                    r_z    <= i_cmd.z;
                    r_rad  <= i_cmd.rad;
                    r_n    <= i_cmd.seg;
                    r_dcnt <= 6'd0;
                    r_rem0 <= 6'd0;
                    r_step <= 32'd0;
                end
            end
            S_DIV: begin
                r_rem0 <= div_rem;
                r_step <= {r_step[30:0], div_ge};
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd32) begin
                    r_rem   <= 6'(r_n >> 1);
                    r_phase <= 32'd0;
                    r_pt    <= '0;
                    r_cent  <= 1'b1;
                    r_px    <= r_cx;
                    r_py    <= r_cy;
                    r_row   <= 2'd0;
                    r_j     <= 2'd0;
                    r_acc   <= '0;
                end
            end
            S_XMUL: begin
                r_quad   <= r_phase[31:30];
                r_mirror <= mirror;
            end
            S_X2: r_x <= x_sum[58:29];
            S_X2R: begin
                r_x2 <= q30r[29:0];
                r_t  <= TRIG_ONE;
                r_i  <= 4'd0;
            end
            S_TDIV: r_v <= q30r + 31'(sdiv >> 1);
            S_CORR: begin
                r_t <= TRIG_ONE - qn;
                r_i <= r_i + 4'd1;
            end
            S_SREG: begin
                r_s <= q30r;
                r_t <= TRIG_ONE;
            end
            S_ROT: begin
                case (r_quad)
                    2'd0: begin
                        r_cmag <= cm; r_cneg <= 1'b0; r_smag <= sm; r_sneg <= 1'b0;
                    end
                    2'd1: begin
                        r_cmag <= sm; r_cneg <= 1'b1; r_smag <= cm; r_sneg <= 1'b0;
                    end
                    2'd2: begin
                        r_cmag <= cm; r_cneg <= 1'b1; r_smag <= sm; r_sneg <= 1'b1;
                    end
                    default: begin
                        r_cmag <= sm; r_cneg <= 1'b0; r_smag <= cm; r_sneg <= 1'b1;
                    end
                endcase
            end
            S_RXADD: r_px <= sat32(rim_x);
            S_RYADD: begin
                r_py  <= sat32(rim_y);
                r_row <= 2'd0;
                r_j   <= 2'd0;
                r_acc <= '0;
            end
            S_MMUL: begin
                if (r_j == 2'd3) begin
                    r_res[r_row] <= sat32(r_acc + ACC_W'($signed(m_sel)));
                    r_acc        <= '0;
                    r_j          <= 2'd0;
                    r_row        <= r_row + 2'd1;
                end
            end
            S_MACC: begin
                r_acc <= r_acc + psig;
                r_j   <= r_j + 2'd1;
            end
            S_VDONE: begin
                if (r_cent) begin
                    r_cen  <= r_res;
                    r_cent <= 1'b0;
                end else if (r_pt == '0) begin
                    r_prev  <= r_res;
                    r_pt    <= r_pt + SEG_W'(1);
                    r_rem   <= adv_wrap ? 6'(adv_sum - r_n) : adv_sum[5:0];
                    r_phase <= r_phase + r_step + 32'(adv_wrap);
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    r_oa    <= r_cen;
                    r_ob    <= r_prev;
                    r_oc    <= r_res;
                    r_olast <= (r_pt == r_n);
                    r_prev  <= r_res;
                    r_pt    <= r_pt + SEG_W'(1);
                    r_rem   <= adv_wrap ? 6'(adv_sum - r_n) : adv_sum[5:0];
                    r_phase <= r_phase + r_step + 32'(adv_wrap);
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_a_x   = r_oa[0];
    assign o_a_y   = r_oa[1];
    assign o_a_z   = r_oa[2];
    assign o_b_x   = r_ob[0];
    assign o_b_y   = r_ob[1];
    assign o_b_z   = r_ob[2];
    assign o_c_x   = r_oc[0];
    assign o_c_y   = r_oc[1];
    assign o_c_z   = r_oc[2];
    assign o_last  = r_olast;

    a_pt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DIV) |-> (r_pt <= r_n))
        else $error("rim point index ran past segment count");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && r_pt == r_n) |=> (r_state == S_IDLE))
        else $error("draw did not end after its last triangle");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DIV) |-> ({1'b0, r_rem} < r_n))
        else $error("phase remainder not below segment count");

endmodule
